// ----- rtl/core/hrhs_pkg.sv -----
// Shared types, character codes and the header key for the HTTP request header scanner.
`default_nettype none

package hrhs_pkg;

  localparam int HEADER_MAX_DEF    = 4096;
  localparam int METHOD_BUFFER_DEF = 16;

  localparam int STATUS_W  = 2;
  localparam int MLEN_W    = 4;
  localparam int PATH_W    = 12;
  localparam int CLEN_W    = 32;
  localparam int KEY_IDX_W = 4;
  localparam int KEY_LEN   = 15;

  localparam logic [KEY_IDX_W-1:0] KEY_FAILED = 4'hF;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  localparam logic [CLEN_W-1:0] MAGNITUDE_CAP = 32'h8000_0000;
  localparam logic [CLEN_W-1:0] POSITIVE_MAX  = 32'h7FFF_FFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_METHOD   = 2'd1,
    ST_NO_PATH_END = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic first_space;
    logic second_space;
    logic carriage_return;
    logic line_feed;
  } delim_flags_t;

  typedef struct packed {
    logic              found;
    logic              negative;
    logic [CLEN_W-1:0] magnitude;
  } clen_value_t;

  function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hrhs_if.sv -----
// Valid/ready channel interfaces for header bytes and scan results.
`default_nettype none

interface hrhs_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       final_byte;

  modport source (output valid, output header_byte, output final_byte, input ready);
  modport sink (input valid, input header_byte, input final_byte, output ready);
endinterface

interface hrhs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [hrhs_pkg::STATUS_W-1:0]       status;
  logic [hrhs_pkg::MLEN_W-1:0]         method_length;
  logic [hrhs_pkg::PATH_W-1:0]         path_offset;
  logic [hrhs_pkg::PATH_W-1:0]         path_length;
  logic signed [hrhs_pkg::CLEN_W-1:0]  body_length;

  modport source (output valid, output status, output method_length, output path_offset,
                  output path_length, output body_length, input ready);
  modport sink (input valid, input status, input method_length, input path_offset,
                input path_length, input body_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hrhs_delim.sv -----
// Byte position counter and first space, second space, CR and LF position tracking.
`default_nettype none

module hrhs_delim #(
  parameter int HEADER_MAX = hrhs_pkg::HEADER_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [7:0]                     header_byte,
  input  wire logic                           final_byte,
  output logic                                take,
  output hrhs_pkg::delim_flags_t              flags,
  output logic [$clog2(HEADER_MAX)-1:0]       raw_method_length,
  output logic [$clog2(HEADER_MAX)-1:0]       path_end
);

  localparam int CNT_W = $clog2(HEADER_MAX + 1);
  localparam int POS_W = $clog2(HEADER_MAX);

  logic [CNT_W-1:0]      byte_position;
  hrhs_pkg::delim_flags_t seen;
  logic [POS_W-1:0]      method_position;
  logic [POS_W-1:0]      second_space_position;
  logic [POS_W-1:0]      carriage_return_position;
  logic [POS_W-1:0]      line_feed_position;

  hrhs_pkg::delim_flags_t seen_next;
  logic [POS_W-1:0]      method_position_next;
  logic [POS_W-1:0]      second_space_position_next;
  logic [POS_W-1:0]      carriage_return_position_next;
  logic [POS_W-1:0]      line_feed_position_next;
  logic [POS_W-1:0]      pos;

  assign take = byte_position < CNT_W'(HEADER_MAX);
  assign pos  = byte_position[POS_W-1:0];

  always_comb begin
    seen_next                     = seen;
    method_position_next          = method_position;
    second_space_position_next    = second_space_position;
    carriage_return_position_next = carriage_return_position;
    line_feed_position_next       = line_feed_position;
    if (take) begin
      if (header_byte == hrhs_pkg::CH_SPACE) begin
        if (!seen.first_space) begin
          seen_next.first_space = 1'b1;
          method_position_next  = pos;
        end else if (!seen.second_space) begin
          seen_next.second_space     = 1'b1;
          second_space_position_next = pos;
        end
      end else if (header_byte == hrhs_pkg::CH_CR) begin
        if (seen.first_space && !seen.carriage_return) begin
          seen_next.carriage_return     = 1'b1;
          carriage_return_position_next = pos;
        end
      end else if (header_byte == hrhs_pkg::CH_LF) begin
        if (seen.first_space && !seen.line_feed) begin
          seen_next.line_feed     = 1'b1;
          line_feed_position_next = pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      byte_position <= '0;
      seen          <= '0;
    end else if (step) begin
      byte_position <= byte_position + CNT_W'(take);
      seen          <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      method_position          <= method_position_next;
      second_space_position    <= second_space_position_next;
      carriage_return_position <= carriage_return_position_next;
      line_feed_position       <= line_feed_position_next;
    end
  end

  assign flags             = seen_next;
  assign raw_method_length = method_position_next;

  always_comb begin
    if (seen_next.second_space) begin
      path_end = second_space_position_next;
    end else if (seen_next.carriage_return) begin
      path_end = carriage_return_position_next;
    end else begin
      path_end = line_feed_position_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrhs_clen.sv -----
// Content-Length key match and signed decimal value accumulation.
`default_nettype none

module hrhs_clen (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  take,
  input  wire logic [7:0]            header_byte,
  input  wire logic                  final_byte,
  output hrhs_pkg::clen_value_t      value
);

  localparam int PROD_W = hrhs_pkg::CLEN_W + 4;

  logic [hrhs_pkg::KEY_IDX_W-1:0] key_match_index;
  logic                           at_line_start;
  hrhs_pkg::phase_t               length_phase;
  logic                           length_negative;
  logic [hrhs_pkg::CLEN_W-1:0]    length_accumulator;

  logic [hrhs_pkg::KEY_IDX_W-1:0] key_match_index_next;
  logic                           at_line_start_next;
  hrhs_pkg::phase_t               length_phase_next;
  logic                           length_negative_next;
  logic [hrhs_pkg::CLEN_W-1:0]    length_accumulator_next;

  logic [7:0]                     lower;
  logic [hrhs_pkg::KEY_IDX_W-1:0] idx;
  logic [hrhs_pkg::KEY_IDX_W-1:0] idx_inc;
  logic                           blank;
  logic                           digit;
  logic [PROD_W-1:0]              product;
  logic [hrhs_pkg::CLEN_W-1:0]    accumulated;

  assign lower = (header_byte >= hrhs_pkg::CH_UPPER_A && header_byte <= hrhs_pkg::CH_UPPER_Z)
               ? header_byte + hrhs_pkg::CASE_SHIFT : header_byte;
  assign idx     = at_line_start ? '0 : key_match_index;
  assign idx_inc = idx + 1'b1;
  assign blank = header_byte == hrhs_pkg::CH_SPACE || header_byte == hrhs_pkg::CH_TAB ||
                 header_byte == hrhs_pkg::CH_LF || header_byte == hrhs_pkg::CH_CR ||
                 header_byte == hrhs_pkg::CH_VT || header_byte == hrhs_pkg::CH_FF;
  assign digit = header_byte >= hrhs_pkg::CH_ZERO && header_byte <= hrhs_pkg::CH_NINE;

  // Multiply by ten as two shifted copies, then cap the magnitude at 2^31.
  assign product = ({4'b0, length_accumulator} << 3) + ({4'b0, length_accumulator} << 1)
                 + PROD_W'(header_byte - hrhs_pkg::CH_ZERO);
  assign accumulated = (product > PROD_W'(hrhs_pkg::MAGNITUDE_CAP))
                     ? hrhs_pkg::MAGNITUDE_CAP : product[hrhs_pkg::CLEN_W-1:0];

  always_comb begin
    key_match_index_next    = key_match_index;
    at_line_start_next      = at_line_start;
    length_phase_next       = length_phase;
    length_negative_next    = length_negative;
    length_accumulator_next = length_accumulator;
    if (take) begin
      at_line_start_next = header_byte == hrhs_pkg::CH_LF;
      case (length_phase)
        hrhs_pkg::PH_SEARCH: begin
          if (idx < hrhs_pkg::KEY_IDX_W'(hrhs_pkg::KEY_LEN) && lower == hrhs_pkg::key_char(idx)) begin
            key_match_index_next = idx_inc;
            if (idx_inc == hrhs_pkg::KEY_IDX_W'(hrhs_pkg::KEY_LEN) && !final_byte) begin
              length_phase_next = hrhs_pkg::PH_SKIP;
            end
          end else begin
            key_match_index_next = hrhs_pkg::KEY_FAILED;
          end
        end
        hrhs_pkg::PH_SKIP: begin
          if (blank) begin
            length_phase_next = hrhs_pkg::PH_SKIP;
          end else if (header_byte == hrhs_pkg::CH_PLUS) begin
            length_phase_next = hrhs_pkg::PH_DIGITS;
          end else if (header_byte == hrhs_pkg::CH_MINUS) begin
            length_negative_next = 1'b1;
            length_phase_next    = hrhs_pkg::PH_DIGITS;
          end else if (digit) begin
            length_accumulator_next = accumulated;
            length_phase_next       = hrhs_pkg::PH_DIGITS;
          end else begin
            length_phase_next = hrhs_pkg::PH_DONE;
          end
        end
        hrhs_pkg::PH_DIGITS: begin
          if (digit) begin
            length_accumulator_next = accumulated;
          end else begin
            length_phase_next = hrhs_pkg::PH_DONE;
          end
        end
        default: begin
          length_phase_next = length_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      key_match_index    <= '0;
      at_line_start      <= 1'b1;
      length_phase       <= hrhs_pkg::PH_SEARCH;
      length_negative    <= 1'b0;
      length_accumulator <= '0;
    end else if (step) begin
      key_match_index    <= key_match_index_next;
      at_line_start      <= at_line_start_next;
      length_phase       <= length_phase_next;
      length_negative    <= length_negative_next;
      length_accumulator <= length_accumulator_next;
    end
  end

  assign value.found     = length_phase_next != hrhs_pkg::PH_SEARCH;
  assign value.negative  = length_negative_next;
  assign value.magnitude = length_accumulator_next;

endmodule

`default_nettype wire

// ----- rtl/core/http_request_header_scanner_unit.sv -----
// Top level of the HTTP request header scanner: input register, scan logic, result register.
`default_nettype none

// Takes one header byte per cycle, except while a final byte waits, and gives one result
// transaction for each header, after the byte marked final. A byte sits in the input
// register while the scan logic folds it into the scan state, and a final byte, when it is
// folded, also loads the result register, from which the result is offered.
// Only a final byte waits for the result register to be free; while a result is held, bytes
// of the next header keep flowing. Bytes past HEADER_MAX are not scanned, but their final
// flag still ends the header.
module http_request_header_scanner_unit #(
  parameter int HEADER_MAX    = hrhs_pkg::HEADER_MAX_DEF,
  parameter int METHOD_BUFFER = hrhs_pkg::METHOD_BUFFER_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hrhs_req_if.sink    req,
  hrhs_rsp_if.source  rsp
);

  localparam int POS_W = $clog2(HEADER_MAX);
  localparam int EXT_W = (POS_W + 1 > hrhs_pkg::PATH_W) ? POS_W + 1 : hrhs_pkg::PATH_W;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_final;
  logic       step;
  logic       result_free;

  logic                   take;
  hrhs_pkg::delim_flags_t flags;
  logic [POS_W-1:0]       raw_method_length;
  logic [POS_W-1:0]       path_end;
  hrhs_pkg::clen_value_t  clen;

  logic                               result_valid;
  hrhs_pkg::status_t                  result_status;
  logic [hrhs_pkg::MLEN_W-1:0]        result_method_length;
  logic [hrhs_pkg::PATH_W-1:0]        result_path_offset;
  logic [hrhs_pkg::PATH_W-1:0]        result_path_length;
  logic [hrhs_pkg::CLEN_W-1:0]        result_body_length;

  hrhs_pkg::status_t                  status_next;
  logic [POS_W-1:0]                   method_clamped;
  logic [EXT_W-1:0]                   offset_ext;
  logic [EXT_W-1:0]                   length_ext;
  logic [hrhs_pkg::CLEN_W-1:0]        content_next;

  assign result_free = !result_valid || rsp.ready;
  assign step        = stage_valid && (!stage_final || result_free);
  assign req.ready   = !rst && (!stage_valid || step);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_byte  <= req.header_byte;
      stage_final <= req.final_byte;
    end
  end

  hrhs_delim #(
    .HEADER_MAX (HEADER_MAX)
  ) u_delim (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .header_byte       (stage_byte),
    .final_byte        (stage_final),
    .take              (take),
    .flags             (flags),
    .raw_method_length (raw_method_length),
    .path_end          (path_end)
  );

  hrhs_clen u_clen (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .take        (take),
    .header_byte (stage_byte),
    .final_byte  (stage_final),
    .value       (clen)
  );

  always_comb begin
    if (!flags.first_space || raw_method_length == '0) begin
      status_next = hrhs_pkg::ST_NO_METHOD;
    end else if (!(flags.second_space || flags.carriage_return || flags.line_feed)) begin
      status_next = hrhs_pkg::ST_NO_PATH_END;
    end else begin
      status_next = hrhs_pkg::ST_OK;
    end
  end

  assign method_clamped = (raw_method_length > POS_W'(METHOD_BUFFER - 1))
                        ? POS_W'(METHOD_BUFFER - 1) : raw_method_length;
  assign offset_ext = EXT_W'(raw_method_length) + 1'b1;
  assign length_ext = EXT_W'(path_end) - offset_ext;

  always_comb begin
    if (!clen.found) begin
      content_next = '0;
    end else if (clen.negative) begin
      content_next = '0 - clen.magnitude;
    end else if (clen.magnitude[hrhs_pkg::CLEN_W-1]) begin
      content_next = hrhs_pkg::POSITIVE_MAX;
    end else begin
      content_next = clen.magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && stage_final) begin
      result_valid <= 1'b1;
    end else if (rsp.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stage_final) begin
      result_status <= status_next;
      if (status_next == hrhs_pkg::ST_OK) begin
        result_method_length <= method_clamped[hrhs_pkg::MLEN_W-1:0];
        result_path_offset   <= offset_ext[hrhs_pkg::PATH_W-1:0];
        result_path_length   <= length_ext[hrhs_pkg::PATH_W-1:0];
        result_body_length   <= content_next;
      end else begin
        result_method_length <= '0;
        result_path_offset   <= '0;
        result_path_length   <= '0;
        result_body_length   <= '0;
      end
    end
  end

  assign rsp.valid         = result_valid;
  assign rsp.status        = result_status;
  assign rsp.method_length = result_method_length;
  assign rsp.path_offset   = result_path_offset;
  assign rsp.path_length   = result_path_length;
  assign rsp.body_length   = result_body_length;

endmodule

`default_nettype wire

// ----- rtl/core/hrhs_checker.sv -----
// Port-level assertions for the HTTP request header scanner, bound to the top level.
`default_nettype none

module hrhs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [3:0]  rsp_method_length,
  input wire logic [11:0] rsp_path_offset,
  input wire logic [11:0] rsp_path_length,
  input wire logic [31:0] rsp_body_length
);

  // A result transaction waiting for the sink stays offered.
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_method_length) &&
      $stable(rsp_path_offset) && $stable(rsp_path_length) && $stable(rsp_body_length))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("undefined status code");

  // Error results carry no method, path or length.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != 2'd0 |-> rsp_method_length == 4'd0 &&
      rsp_path_offset == 12'd0 && rsp_path_length == 12'd0 && rsp_body_length == 32'd0)
    else $error("error result with nonzero fields");

  a_reset_idle: assert property (@(posedge clk) !rst && $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind http_request_header_scanner_unit hrhs_checker u_hrhs_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_method_length (rsp.method_length),
  .rsp_path_offset   (rsp.path_offset),
  .rsp_path_length   (rsp.path_length),
  .rsp_body_length   (rsp.body_length)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the HTTP request header scanner with random handshakes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrhs_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PERCENT   = 23;
  localparam int STEADY_FROM    = 300;
  localparam int STEADY_TO      = 650;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_BYTES   = 950;
  localparam int RANDOM_HEADERS = 10;
  localparam int HEADER_LIMIT   = HEADER_MAX_DEF;

  localparam logic [MLEN_W-1:0]     METHOD_KEEP = MLEN_W'(METHOD_BUFFER_DEF - 1);
  localparam logic [8*KEY_LEN-1:0] CL_KEY      = "content-length:";

  typedef struct packed {
    logic       hold;
    logic       final_byte;
    logic [7:0] header_byte;
  } byte_item_t;

  typedef struct packed {
    status_t             status;
    logic [MLEN_W-1:0]   method_length;
    logic [PATH_W-1:0]   path_offset;
    logic [PATH_W-1:0]   path_length;
    logic [CLEN_W-1:0]   body_length;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrhs_req_if req ();
  hrhs_rsp_if rsp ();

  http_request_header_scanner_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  byte_item_t   bytes_to_send[$];
  scan_result_t scans_in_flight[$];
  logic [7:0]   hdr[$];

  int   cycle_no       = 0;
  int   idle_cycles    = 0;
  int   mismatch_count = 0;
  int   byte_total     = 0;
  int   header_total   = 0;
  logic req_fired      = 1'b0;

  logic [12:0]       scan_pos;
  logic              line_start;
  logic              sp1_seen;
  logic [12:0]       sp1_pos;
  logic              sp2_seen;
  logic [12:0]       sp2_pos;
  logic              cr_seen;
  logic [12:0]       cr_pos;
  logic              lf_seen;
  logic [12:0]       lf_pos;
  logic [KEY_IDX_W-1:0] key_idx;
  phase_t            phase;
  logic              negative;
  logic [CLEN_W-1:0] magnitude;

  function automatic logic [7:0] key_byte(input int idx);
    return CL_KEY[8*(KEY_LEN-1-idx) +: 8];
  endfunction

  function automatic logic in_steady_stretch();
    return cycle_no >= STEADY_FROM && cycle_no < STEADY_TO;
  endfunction

  task automatic clear_scan();
    scan_pos   = '0;
    line_start = 1'b1;
    sp1_seen   = 1'b0;
    sp1_pos    = '0;
    sp2_seen   = 1'b0;
    sp2_pos    = '0;
    cr_seen    = 1'b0;
    cr_pos     = '0;
    lf_seen    = 1'b0;
    lf_pos     = '0;
    key_idx    = '0;
    phase      = PH_SEARCH;
    negative   = 1'b0;
    magnitude  = '0;
  endtask

  task automatic push_digit(input logic [7:0] b);
    logic [35:0] grown;
    grown = {4'b0, magnitude} * 36'd10 + 36'(b - CH_ZERO);
    magnitude = (grown > {4'b0, MAGNITUDE_CAP}) ? MAGNITUDE_CAP : grown[CLEN_W-1:0];
  endtask

  task automatic fold_header_byte(input logic [7:0] b, input logic fin);
    logic [7:0]   folded;
    logic         blank;
    logic         have_end;
    logic [12:0]  path_start;
    logic [12:0]  path_end;
    logic [12:0]  span;
    scan_result_t res;
    if (scan_pos < HEADER_LIMIT) begin
      folded = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_SHIFT : b;
      blank  = b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
               b == CH_VT || b == CH_FF;
      if (b == CH_SPACE) begin
        if (!sp1_seen) begin
          sp1_seen = 1'b1;
          sp1_pos  = scan_pos;
        end else if (!sp2_seen) begin
          sp2_seen = 1'b1;
          sp2_pos  = scan_pos;
        end
      end else if (b == CH_CR) begin
        if (sp1_seen && !cr_seen) begin
          cr_seen = 1'b1;
          cr_pos  = scan_pos;
        end
      end else if (b == CH_LF) begin
        if (sp1_seen && !lf_seen) begin
          lf_seen = 1'b1;
          lf_pos  = scan_pos;
        end
      end
      case (phase)
        PH_SEARCH: begin
          if (line_start) key_idx = '0;
          if (key_idx < KEY_LEN && folded == key_byte(key_idx)) begin
            key_idx = key_idx + 1'b1;
            if (key_idx == KEY_LEN && !fin) phase = PH_SKIP;
          end else begin
            key_idx = KEY_FAILED;
          end
        end
        PH_SKIP: begin
          if (!blank) begin
            if (b == CH_PLUS) begin
              phase = PH_DIGITS;
            end else if (b == CH_MINUS) begin
              negative = 1'b1;
              phase    = PH_DIGITS;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
              push_digit(b);
              phase = PH_DIGITS;
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) push_digit(b);
          else phase = PH_DONE;
        end
        default: begin
        end
      endcase
      line_start = (b == CH_LF);
      scan_pos   = scan_pos + 1'b1;
    end
    if (fin) begin
      res = '0;
      if (!sp1_seen || sp1_pos == 0) begin
        res.status = ST_NO_METHOD;
      end else begin
        have_end = 1'b1;
        path_end = '0;
        if (sp2_seen) path_end = sp2_pos;
        else if (cr_seen) path_end = cr_pos;
        else if (lf_seen) path_end = lf_pos;
        else have_end = 1'b0;
        if (!have_end) begin
          res.status = ST_NO_PATH_END;
        end else begin
          path_start = sp1_pos + 13'd1;
          span       = path_end - path_start;
          res.status        = ST_OK;
          res.method_length = (sp1_pos > METHOD_KEEP) ? METHOD_KEEP : sp1_pos[MLEN_W-1:0];
          res.path_offset   = path_start[PATH_W-1:0];
          res.path_length   = span[PATH_W-1:0];
          if (phase != PH_SEARCH) begin
            if (negative) res.body_length = ~magnitude + 1'b1;
            else res.body_length = (magnitude > POSITIVE_MAX) ? POSITIVE_MAX : magnitude;
          end
        end
      end
      scans_in_flight.push_back(res);
      clear_scan();
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    hdr.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic send_header();
    byte_item_t it;
    foreach (hdr[i]) begin
      it.hold        = 1'b0;
      it.final_byte  = (i == hdr.size() - 1);
      it.header_byte = hdr[i];
      bytes_to_send.push_back(it);
    end
    byte_total += hdr.size();
    header_total++;
    hdr.delete();
  endtask

  task automatic add_hold();
    byte_item_t it;
    it      = '0;
    it.hold = 1'b1;
    bytes_to_send.push_back(it);
  endtask

  task automatic add_length_line(output logic cut);
    logic [7:0] c;
    cut = 1'b0;
    for (int i = 0; i < KEY_LEN; i++) begin
      c = key_byte(i);
      if (c >= CH_UPPER_A + CASE_SHIFT && c <= CH_UPPER_Z + CASE_SHIFT && $urandom_range(0, 1))
        c = c - CASE_SHIFT;
      add_byte(c);
    end
    if ($urandom_range(0, 19) == 0) begin
      cut = 1'b1;
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0:       add_byte(CH_SPACE);
        1:       add_byte(CH_TAB);
        2:       add_byte(CH_CR);
        3:       add_byte(CH_LF);
        4:       add_byte(CH_VT);
        default: add_byte(CH_FF);
      endcase
    end
    case ($urandom_range(0, 9))
      6, 7:    add_byte(CH_PLUS);
      8, 9:    add_byte(CH_MINUS);
      default: begin
      end
    endcase
    case ($urandom_range(0, 9))
      5: add_text($sformatf("%0d", $urandom));
      6: begin
        case ($urandom_range(0, 3))
          0:       add_text("2147483647");
          1:       add_text("2147483648");
          2:       add_text("2147483649");
          default: add_text("0");
        endcase
      end
      7: repeat ($urandom_range(11, 20)) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      8: begin
      end
      9: add_text($sformatf("000%0d", $urandom_range(0, 999)));
      default: add_text($sformatf("%0d", $urandom_range(0, 99999)));
    endcase
    if ($urandom_range(0, 19) == 0) begin
      cut = 1'b1;
      return;
    end
    if ($urandom_range(0, 4) == 0) add_text(";q");
    add_crlf();
  endtask

  task automatic build_request();
    int   method_len;
    int   n_lines;
    int   cl_line;
    logic cut;
    method_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(3, 7);
    repeat (method_len) add_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
    add_byte(CH_SPACE);
    add_byte("/");
    repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    case ($urandom_range(0, 9))
      0:       add_crlf();
      1:       add_byte(CH_LF);
      2: begin
      end
      default: begin
        add_text(" HTTP/1.1");
        add_crlf();
      end
    endcase
    n_lines = $urandom_range(0, 3);
    cl_line = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n_lines) : -1;
    for (int i = 0; i <= n_lines; i++) begin
      if (i == cl_line) begin
        add_length_line(cut);
        if (cut) return;
      end
      if (i < n_lines) begin
        case ($urandom_range(0, 4))
          0:       add_text("Host: unit.test");
          1:       add_text("Accept: */*");
          2:       add_text("X-Content-Length: 9");
          3:       add_text(" Content-Length: 77");
          default: add_text("Content-Length 12");
        endcase
        add_crlf();
      end
    end
    add_crlf();
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(negedge clk) begin : drive_bytes
    byte_item_t head;
    logic       drive_valid;
    drive_valid = req.valid;
    if (rst) begin
      drive_valid = 1'b0;
    end else if (!req.valid || req_fired) begin
      drive_valid = 1'b0;
      if (bytes_to_send.size() > 0) begin
        head = bytes_to_send[0];
        if (head.hold) begin
          if (scans_in_flight.size() == 0) void'(bytes_to_send.pop_front());
        end else if (in_steady_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT) begin
          void'(bytes_to_send.pop_front());
          drive_valid = 1'b1;
          req.header_byte <= head.header_byte;
          req.final_byte  <= head.final_byte;
        end
      end
    end
    req.valid <= drive_valid;
  end

  always @(negedge clk) begin : drive_ready
    rsp.ready <= !rst && (in_steady_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin : watch_channels
    scan_result_t want;
    logic         moved;
    cycle_no++;
    req_fired = 1'b0;
    moved     = 1'b0;
    if (!rst) begin
      if (req.valid && req.ready) begin
        req_fired = 1'b1;
        moved     = 1'b1;
        fold_header_byte(req.header_byte, req.final_byte);
      end
      if (rsp.valid && rsp.ready) begin
        moved = 1'b1;
        if (scans_in_flight.size() == 0) begin
          $display("%0t: result transaction with no header outstanding", $time);
          mismatch_count++;
        end else begin
          want = scans_in_flight.pop_front();
          if (rsp.status !== want.status)
            report_field("status", want.status, rsp.status);
          if (rsp.method_length !== want.method_length)
            report_field("method_length", want.method_length, rsp.method_length);
          if (rsp.path_offset !== want.path_offset)
            report_field("path_offset", want.path_offset, rsp.path_offset);
          if (rsp.path_length !== want.path_length)
            report_field("path_length", want.path_length, rsp.path_length);
          if (rsp.body_length !== want.body_length)
            report_field("body_length", $signed(want.body_length), rsp.body_length);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : run_test
    int kind;
    int keep;
    req.valid       = 1'b0;
    req.header_byte = '0;
    req.final_byte  = 1'b0;
    rsp.ready       = 1'b0;
    clear_scan();

    add_text("A B ");
    send_header();
    add_text(" x");
    send_header();
    add_text("ab c");
    send_header();
    add_byte(8'hFF);
    send_header();
    add_byte(8'h00);
    send_header();
    add_text("a /");
    add_byte(CH_LF);
    send_header();
    add_text("a /");
    add_byte(CH_CR);
    send_header();
    add_hold();

    byte_total   = 0;
    header_total = 0;
    while (byte_total < RANDOM_BYTES || header_total < RANDOM_HEADERS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      end else begin
        build_request();
        if (kind < 16 && hdr.size() > 1) begin
          keep = $urandom_range(1, hdr.size() - 1);
          while (hdr.size() > keep) void'(hdr.pop_back());
        end
      end
      send_header();
      if ($urandom_range(0, 29) == 0) add_hold();
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    while (bytes_to_send.size() != 0 || req.valid || scans_in_flight.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
